@@ rtl/bimm_pkg.sv @@
// ----------------------------------------------------------------------------
// bimm_pkg
// Shared types and constants for the batched integer matrix multiply block.
// ----------------------------------------------------------------------------
package bimm_pkg;

   // Default sizes of the element stores.
   localparam int MAX_DIM_DEF   = 16;
   localparam int MAX_BATCH_DEF = 4;

   // Fixed field widths.
   localparam int VALUE_W   = 32;
   localparam int CMD_W     = 2;
   localparam int BATCH_W   = 2;
   localparam int INDEX_W   = 4;
   localparam int DIM_REG_W = 5;
   localparam int BCNT_W    = 3;
   localparam int REQ_DATA_W = 48;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Command codes carried in the request tuser.
   localparam logic [CMD_W-1:0] CMD_LOAD_LEFT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_RIGHT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE    = 2'd2;

   // Register indexes (byte address / 4).
   localparam logic [2:0] REG_ELEMENT_TYPE = 3'd0;
   localparam logic [2:0] REG_ROWS_A       = 3'd1;
   localparam logic [2:0] REG_INNER_LEN    = 3'd2;
   localparam logic [2:0] REG_COLS_B       = 3'd3;
   localparam logic [2:0] REG_BATCH_COUNT  = 3'd4;

   // Element type codes.
   localparam logic ETYPE_UINT8 = 1'b0;
   localparam logic ETYPE_INT32 = 1'b1;

   // Control from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic clear;   // start a new dot product
      logic step;    // operand pair on the unit's inputs is valid
      logic narrow;  // unsigned 8-bit operands
   } mac_ctrl_type;

endpackage

@@ rtl/bimm_ram.sv @@
// ----------------------------------------------------------------------------
// bimm_ram
// Single-port-write, single-port-read element store with registered read data.
// ----------------------------------------------------------------------------
module bimm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bimm_mac.sv @@
// ----------------------------------------------------------------------------
// bimm_mac
// Shared multiply-accumulate unit: one registered product, one accumulator.
// ----------------------------------------------------------------------------
module bimm_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  bimm_pkg::mac_ctrl_type        ctrl,
   input  logic [bimm_pkg::VALUE_W-1:0]  left_op,
   input  logic [bimm_pkg::VALUE_W-1:0]  right_op,
   output logic [bimm_pkg::VALUE_W-1:0]  acc
);

   logic [bimm_pkg::VALUE_W-1:0]   a_op;
   logic [bimm_pkg::VALUE_W-1:0]   w_op;
   logic [bimm_pkg::VALUE_W-1:0]   prod_low;
   logic [bimm_pkg::VALUE_W-1:0]   prod_ff;
   logic                           prod_valid_ff;
   logic                           prod_valid_in;
   logic [bimm_pkg::VALUE_W-1:0]   acc_ff;

   // In 8-bit mode only the low byte of each operand takes part.
   assign a_op = ctrl.narrow ? {24'd0, left_op[7:0]}  : left_op;
   assign w_op = ctrl.narrow ? {24'd0, right_op[7:0]} : right_op;
   assign prod_low = a_op * w_op;
   assign prod_valid_in = ctrl.step & ~ctrl.clear;

   // Product stage; the sum wraps modulo 2^32 so only the low word is kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_low;
   end

   // Accumulator stage.
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   assign acc = acc_ff;

endmodule

@@ rtl/batched_integer_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// batched_integer_matrix_multiply
// Batched matrix multiply over two element stores, one output element per
// compute command.
// ----------------------------------------------------------------------------
// Load items write one element of the left or right store and produce no
// result, so loads can follow back to back. A compute item walks the inner
// dimension (inner_len, at most MAX_DIM) through one shared
// multiply-accumulate unit, one term per cycle, fed by the two stores'
// registered read ports; the drain state then lets the read and product
// stages empty before the result is moved into the output register, which
// waits while a previous result is still held on the rsp side. The block
// takes no new item until the result has been moved into the output
// register. An out-of-range compute, or one with a zero inner length, goes
// from acceptance straight to the done state, skipping the run and drain
// states. The result register lets the next item be accepted while a
// result still waits on the rsp side.
// Store entries are not cleared by reset; reading an entry never written gives
// an unspecified value.
// ----------------------------------------------------------------------------
module batched_integer_matrix_multiply #(
   parameter int MAX_DIM   = bimm_pkg::MAX_DIM_DEF,
   parameter int MAX_BATCH = bimm_pkg::MAX_BATCH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata fields from bit 0: batch[1:0], row[5:2], col[9:6], value[41:10], zero pad
   input  logic [bimm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser fields from bit 0: command[1:0]
   input  logic [bimm_pkg::CMD_W-1:0]        req_tuser,
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata fields from bit 0: result_value[31:0]
   output logic [bimm_pkg::VALUE_W-1:0]      rsp_tdata,
   // tuser fields from bit 0: status[0]
   output logic                              rsp_tuser,
   // Configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bimm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bimm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bimm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int STORE_DEPTH = MAX_BATCH * MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int VW          = bimm_pkg::VALUE_W;
   localparam int DW          = bimm_pkg::DIM_REG_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // Request fields.
   logic [bimm_pkg::BATCH_W-1:0] req_batch;
   logic [bimm_pkg::INDEX_W-1:0] req_row;
   logic [bimm_pkg::INDEX_W-1:0] req_col;
   logic [VW-1:0]                req_value;

   assign req_batch = req_tdata[1:0];
   assign req_row   = req_tdata[5:2];
   assign req_col   = req_tdata[9:6];
   assign req_value = req_tdata[41:10];

   // Configuration registers.
   logic          element_type_ff;
   logic [DW-1:0] rows_a_ff;
   logic [DW-1:0] inner_len_ff;
   logic [DW-1:0] cols_b_ff;
   logic [bimm_pkg::BCNT_W-1:0] batch_count_ff;
   logic          csr_write;
   logic [2:0]    csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         element_type_ff <= bimm_pkg::ETYPE_INT32;
         rows_a_ff       <= DW'(16);
         inner_len_ff    <= DW'(16);
         cols_b_ff       <= DW'(16);
         batch_count_ff  <= bimm_pkg::BCNT_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            bimm_pkg::REG_ELEMENT_TYPE: element_type_ff <= csr_pwdata[0];
            bimm_pkg::REG_ROWS_A:       rows_a_ff       <= csr_pwdata[DW-1:0];
            bimm_pkg::REG_INNER_LEN:    inner_len_ff    <= csr_pwdata[DW-1:0];
            bimm_pkg::REG_COLS_B:       cols_b_ff       <= csr_pwdata[DW-1:0];
            bimm_pkg::REG_BATCH_COUNT:  batch_count_ff  <= csr_pwdata[bimm_pkg::BCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         bimm_pkg::REG_ELEMENT_TYPE: csr_prdata = {31'd0, element_type_ff};
         bimm_pkg::REG_ROWS_A:       csr_prdata = {27'd0, rows_a_ff};
         bimm_pkg::REG_INNER_LEN:    csr_prdata = {27'd0, inner_len_ff};
         bimm_pkg::REG_COLS_B:       csr_prdata = {27'd0, cols_b_ff};
         bimm_pkg::REG_BATCH_COUNT:  csr_prdata = {29'd0, batch_count_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   // Range checks; a dimension register above the store size acts as the store size.
   logic batch_ok;
   logic row_in_rows;
   logic row_in_inner;
   logic col_in_inner;
   logic col_in_cols;

   assign batch_ok     = (32'(req_batch) < 32'(batch_count_ff)) && (32'(req_batch) < MAX_BATCH);
   assign row_in_rows  = (32'(req_row) < 32'(rows_a_ff))    && (32'(req_row) < MAX_DIM);
   assign row_in_inner = (32'(req_row) < 32'(inner_len_ff)) && (32'(req_row) < MAX_DIM);
   assign col_in_inner = (32'(req_col) < 32'(inner_len_ff)) && (32'(req_col) < MAX_DIM);
   assign col_in_cols  = (32'(req_col) < 32'(cols_b_ff))    && (32'(req_col) < MAX_DIM);

   // Store addresses: (batch * MAX_DIM + row) * MAX_DIM + col.
   logic [ADDR_W-1:0] batch_base;
   logic [ADDR_W-1:0] req_addr;
   logic [ADDR_W-1:0] left_start;
   logic [ADDR_W-1:0] right_start;

   assign batch_base  = ADDR_W'(req_batch) * ADDR_W'(MAX_DIM * MAX_DIM);
   assign req_addr    = batch_base + ADDR_W'(req_row) * ADDR_W'(MAX_DIM) + ADDR_W'(req_col);
   assign left_start  = batch_base + ADDR_W'(req_row) * ADDR_W'(MAX_DIM);
   assign right_start = batch_base + ADDR_W'(req_col);

   // Handshakes.
   logic req_accept;
   logic rsp_free;
   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   logic left_wr_en;
   logic right_wr_en;
   logic is_compute;
   logic compute_ok;

   assign left_wr_en  = req_accept && (req_tuser == bimm_pkg::CMD_LOAD_LEFT)
                        && batch_ok && row_in_rows && col_in_inner;
   assign right_wr_en = req_accept && (req_tuser == bimm_pkg::CMD_LOAD_RIGHT)
                        && batch_ok && row_in_inner && col_in_cols;
   assign is_compute  = req_accept && (req_tuser == bimm_pkg::CMD_COMPUTE);
   assign compute_ok  = batch_ok && row_in_rows && col_in_cols;

   // Sequencer registers.
   logic [DW-1:0]     k_ff;
   logic [DW-1:0]     k_in;
   logic [DW:0]       k_inc;
   logic              last_term;
   logic              drain_ff;
   logic              drain_in;
   logic [ADDR_W-1:0] left_ptr_ff;
   logic [ADDR_W-1:0] left_ptr_in;
   logic [ADDR_W-1:0] right_ptr_ff;
   logic [ADDR_W-1:0] right_ptr_in;
   logic              rd_valid_ff;
   logic              status_ff;
   logic              status_in;
   logic              rsp_tvalid_ff;
   logic              rsp_tvalid_in;
   logic [VW-1:0]     rsp_data_ff;
   logic              rsp_status_ff;
   logic              issue;
   logic [VW-1:0]     acc;

   assign rsp_free  = ~rsp_tvalid_ff | rsp_tready;
   assign issue     = (state_ff == ST_RUN);
   assign k_inc     = {1'b0, k_ff} + (DW+1)'(1);
   assign last_term = (32'(k_inc) >= 32'(inner_len_ff)) || (32'(k_inc) >= MAX_DIM);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      drain_in      = drain_ff;
      left_ptr_in   = left_ptr_ff;
      right_ptr_in  = right_ptr_ff;
      status_in     = status_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (is_compute) begin
               k_in         = '0;
               left_ptr_in  = left_start;
               right_ptr_in = right_start;
               status_in    = ~compute_ok;
               if (compute_ok && (inner_len_ff != '0)) begin
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RUN: begin
            k_in         = k_inc[DW-1:0];
            left_ptr_in  = left_ptr_ff + ADDR_W'(1);
            right_ptr_in = right_ptr_ff + ADDR_W'(MAX_DIM);
            if (last_term) begin
               state_in = ST_DRAIN;
               drain_in = 1'b0;
            end
         end
         ST_DRAIN: begin
            // Wait here for the read and product stages to empty.
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= issue;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      drain_ff     <= drain_in;
      left_ptr_ff  <= left_ptr_in;
      right_ptr_ff <= right_ptr_in;
      status_ff    <= status_in;
   end

   // Output register; an out-of-range item reports zero, 8-bit mode keeps one byte.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_status_ff <= status_ff;
         if (status_ff) begin
            rsp_data_ff <= '0;
         end else if (element_type_ff == bimm_pkg::ETYPE_UINT8) begin
            rsp_data_ff <= {24'd0, acc[7:0]};
         end else begin
            rsp_data_ff <= acc;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Element stores.
   logic [VW-1:0] left_rd_data;
   logic [VW-1:0] right_rd_data;

   bimm_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (VW)
   ) u_left_store (
      .clock   (clock),
      .wr_en   (left_wr_en),
      .wr_addr (req_addr),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (left_ptr_ff),
      .rd_data (left_rd_data)
   );

   bimm_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (VW)
   ) u_right_store (
      .clock   (clock),
      .wr_en   (right_wr_en),
      .wr_addr (req_addr),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (right_ptr_ff),
      .rd_data (right_rd_data)
   );

   // Shared multiply-accumulate unit.
   bimm_pkg::mac_ctrl_type mac_ctrl;

   assign mac_ctrl.clear  = is_compute;
   assign mac_ctrl.step   = rd_valid_ff;
   assign mac_ctrl.narrow = (element_type_ff == bimm_pkg::ETYPE_UINT8);

   bimm_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .left_op  (left_rd_data),
      .right_op (right_rd_data),
      .acc      (acc)
   );

endmodule
